/* rtl/hrlp_pkg.sv */
package hrlp_pkg;

  // Field size limits
  localparam int METHOD_MAX = 16;
  localparam int PATH_MAX   = 256;
  localparam int BODY_MAX   = 1024;

  // Special characters
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  // Saturation points of the index and the reported length
  localparam logic [10:0] IDX_TOP = 11'd2047;
  localparam logic [9:0]  LEN_TOP = 10'd1023;

  // Field codes for store_target and closed_field
  typedef enum logic [1:0] {
    FLD_NONE   = 2'd0,
    FLD_METHOD = 2'd1,
    FLD_PATH   = 2'd2,
    FLD_BODY   = 2'd3
  } field_t;

  // Phase codes as reported on the result channel
  localparam logic [2:0] PHC_METHOD  = 3'd0;
  localparam logic [2:0] PHC_PATH    = 3'd1;
  localparam logic [2:0] PHC_VERSION = 3'd2;
  localparam logic [2:0] PHC_HEADERS = 3'd3;
  localparam logic [2:0] PHC_BODY    = 3'd4;
  localparam logic [2:0] PHC_DONE    = 3'd5;

  // One result per byte
  typedef struct packed {
    field_t      store_target;
    logic [9:0]  store_position;
    logic [7:0]  store_byte;
    field_t      closed_field;
    logic [9:0]  closed_length;
    logic        request_done;
    logic [2:0]  phase;
  } hrlp_result_t;

endpackage

/* rtl/hrlp_ifs.sv */
interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] store_target;
  logic [9:0] store_position;
  logic [7:0] store_byte;
  logic [1:0] closed_field;
  logic [9:0] closed_length;
  logic       request_done;
  logic [2:0] phase;

  modport source (output valid, output store_target, output store_position,
                  output store_byte, output closed_field, output closed_length,
                  output request_done, output phase, input ready);
  modport sink   (input valid, input store_target, input store_position,
                  input store_byte, input closed_field, input closed_length,
                  input request_done, input phase, output ready);
endinterface

/* rtl/hrlp_core.sv */
module hrlp_core #(
  parameter int METHOD_MAX = hrlp_pkg::METHOD_MAX,
  parameter int PATH_MAX   = hrlp_pkg::PATH_MAX,
  parameter int BODY_MAX   = hrlp_pkg::BODY_MAX
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic [15:0]          body_length,
  output hrlp_pkg::hrlp_result_t res
);
  import hrlp_pkg::*;

  typedef enum logic [5:0] {
    PH_METHOD  = 6'b000001,
    PH_PATH    = 6'b000010,
    PH_VERSION = 6'b000100,
    PH_HEADERS = 6'b001000,
    PH_BODY    = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  localparam logic [10:0] METHOD_LIM = 11'(METHOD_MAX);
  localparam logic [10:0] PATH_LIM   = 11'(PATH_MAX);
  localparam logic [10:0] BODY_LIM   = 11'(BODY_MAX - 1);

  phase_t      phase_r, phase_nxt;
  logic        saw_cr_r, saw_cr_nxt;
  logic        saw_line_end_r, saw_line_end_nxt;
  logic [10:0] idx_r, idx_nxt;

  logic        is_lf, is_cr, is_sp, is_mp, handled;
  logic [10:0] idx_inc, cur_lim, body_lim;
  logic [9:0]  len_cap;
  field_t      cur_fld;
  phase_t      after_sp;

  function automatic logic [9:0] cap_len(input logic [10:0] n);
    cap_len = (n > 11'(LEN_TOP)) ? LEN_TOP : n[9:0];
  endfunction

  // Decode byte and current phase
  assign is_lf    = (data_byte == CH_LF);
  assign is_cr    = (data_byte == CH_CR);
  assign is_sp    = (data_byte == CH_SP);
  assign is_mp    = (phase_r == PH_METHOD) || (phase_r == PH_PATH);
  assign cur_fld  = (phase_r == PH_METHOD) ? FLD_METHOD : FLD_PATH;
  assign cur_lim  = (phase_r == PH_METHOD) ? METHOD_LIM : PATH_LIM;
  assign after_sp = (phase_r == PH_METHOD) ? PH_PATH : PH_VERSION;
  assign idx_inc  = idx_r + 11'd1;
  assign len_cap  = cap_len(idx_r);
  assign body_lim = (body_length > 16'(BODY_LIM)) ? BODY_LIM : body_length[10:0];

  // Next state and result for one byte
  always_comb begin
    phase_nxt        = phase_r;
    saw_cr_nxt       = saw_cr_r;
    saw_line_end_nxt = saw_line_end_r;
    idx_nxt          = idx_r;
    handled          = 1'b0;
    res              = '0;
    res.store_target = FLD_NONE;
    res.closed_field = FLD_NONE;

    if (phase_r == PH_BODY) begin
      res.store_target   = FLD_BODY;
      res.store_position = idx_r[9:0];
      res.store_byte     = data_byte;
      idx_nxt            = idx_inc;
      if (idx_inc >= body_lim) begin
        res.closed_field  = FLD_BODY;
        res.closed_length = cap_len(idx_inc);
        phase_nxt         = PH_DONE;
        saw_cr_nxt        = 1'b0;
        saw_line_end_nxt  = 1'b0;
        idx_nxt           = '0;
      end
    end else if (phase_r != PH_DONE) begin
      // Line end handling
      if (is_lf && saw_cr_r) begin
        if (phase_r != PH_HEADERS) begin
          if (is_mp) begin
            res.closed_field  = cur_fld;
            res.closed_length = len_cap;
          end
          phase_nxt        = PH_HEADERS;
          saw_cr_nxt       = 1'b0;
          saw_line_end_nxt = 1'b1;
          idx_nxt          = '0;
          handled          = 1'b1;
        end else if (saw_line_end_r) begin
          if (body_length == 16'd0) begin
            res.closed_field  = FLD_BODY;
            res.closed_length = '0;
            phase_nxt         = PH_DONE;
          end else begin
            phase_nxt = PH_BODY;
          end
          saw_cr_nxt       = 1'b0;
          saw_line_end_nxt = 1'b0;
          idx_nxt          = '0;
          handled          = 1'b1;
        end else begin
          saw_line_end_nxt = 1'b1;
        end
      end else if (!is_cr) begin
        saw_line_end_nxt = 1'b0;
      end

      // Ordinary bytes: split at space, store or count
      if (!handled) begin
        saw_cr_nxt = is_cr;
        if (is_sp && is_mp) begin
          res.closed_field  = cur_fld;
          res.closed_length = len_cap;
          phase_nxt         = after_sp;
          saw_cr_nxt        = 1'b0;
          saw_line_end_nxt  = 1'b0;
          idx_nxt           = '0;
        end else if (is_mp) begin
          if (idx_r < cur_lim) begin
            res.store_target   = cur_fld;
            res.store_position = idx_r[9:0];
            res.store_byte     = data_byte;
            idx_nxt            = idx_inc;
          end
        end else if (idx_r != IDX_TOP) begin
          idx_nxt = idx_inc;
        end
      end
    end

    // Report the phase after the byte
    unique case (phase_nxt)
      PH_METHOD:  res.phase = PHC_METHOD;
      PH_PATH:    res.phase = PHC_PATH;
      PH_VERSION: res.phase = PHC_VERSION;
      PH_HEADERS: res.phase = PHC_HEADERS;
      PH_BODY:    res.phase = PHC_BODY;
      PH_DONE:    res.phase = PHC_DONE;
      default:    res.phase = PHC_DONE;
    endcase
    res.request_done = (phase_nxt == PH_DONE);
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_METHOD;
      saw_cr_r       <= 1'b0;
      saw_line_end_r <= 1'b0;
      idx_r          <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      saw_cr_r       <= saw_cr_nxt;
      saw_line_end_r <= saw_line_end_nxt;
      idx_r          <= idx_nxt;
    end
  end

`ifndef SYNTH
  a_phase_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_nxt != phase_r) |=> !saw_cr_r && (idx_r == '0))
    else $error("phase change left stale line state");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |=> (phase_r == PH_DONE))
    else $error("parser left the done phase");

  a_body_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (idx_r < BODY_LIM))
    else $error("body index beyond its limit");
`endif

endmodule

/* rtl/http_request_line_parser.sv */
// Parses an HTTP request stream one byte per transfer and sustains one byte
// per clock while the result channel is not stalled: the parser state (phase,
// CR and line-end flags, field index) is updated from the byte held in the
// input register, and the result is held in an output register, so a new
// byte is taken while an earlier result still waits. A result is registered
// in the output register once that register is free and is then transferred
// out from there. Method and path bytes and body bytes come out with their
// field position; the method and path close at a space or CR LF, the headers
// end at a blank line, and the body closes on the byte that reaches
// body_length (capped at BODY_MAX-1). After the done phase every byte yields a
// result with nothing stored or closed that reports the done phase, until reset.
// Write body_length through the configuration port only while no byte is in flight.
module http_request_line_parser #(
  parameter int METHOD_MAX = hrlp_pkg::METHOD_MAX,
  parameter int PATH_MAX   = hrlp_pkg::PATH_MAX,
  parameter int BODY_MAX   = hrlp_pkg::BODY_MAX
) (
  input  logic         clk,
  input  logic         rst_n,
  hrlp_in_if.sink      in_bus,
  hrlp_out_if.source   out_bus,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import hrlp_pkg::*;

  logic         in_valid_r, in_valid_nxt;
  logic [7:0]   in_byte_r;
  logic         out_valid_r, out_valid_nxt;
  hrlp_result_t out_res_r;
  hrlp_result_t step_res;
  logic [15:0]  body_length_r;
  logic         adv;

  // Move the registered byte into the output stage when it is free
  assign adv          = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || adv;

  assign in_valid_nxt  = (in_bus.valid && in_bus.ready) || (in_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_bus.ready);

  hrlp_core #(
    .METHOD_MAX (METHOD_MAX),
    .PATH_MAX   (PATH_MAX),
    .BODY_MAX   (BODY_MAX)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .data_byte   (in_byte_r),
    .body_length (body_length_r),
    .res         (step_res)
  );

  // Handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture input byte and result payload
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_byte_r <= in_bus.data_byte;
    end
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_length_r <= '0;
    end else if (cfg_we) begin
      body_length_r <= cfg_wdata;
    end
  end

  // Drive the result channel
  assign out_bus.valid          = out_valid_r;
  assign out_bus.store_target   = out_res_r.store_target;
  assign out_bus.store_position = out_res_r.store_position;
  assign out_bus.store_byte     = out_res_r.store_byte;
  assign out_bus.closed_field   = out_res_r.closed_field;
  assign out_bus.closed_length  = out_res_r.closed_length;
  assign out_bus.request_done   = out_res_r.request_done;
  assign out_bus.phase          = out_res_r.phase;

`ifndef SYNTH
  a_hold_pending_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_byte_r))
    else $error("pending byte lost or changed");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced byte produced no result");

  a_done_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.request_done == (out_res_r.phase == PHC_DONE)))
    else $error("request_done disagrees with phase");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import hrlp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_GOAL   = 600;

  // How the body of the single request ends
  typedef enum {BODY_EMPTY, BODY_CAPPED, BODY_SHORT, BODY_CUT} body_plan_t;

  typedef struct {
    logic [7:0]   b;
    bit           typed;
    hrlp_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  hrlp_in_if  in_bus ();
  hrlp_out_if out_bus ();

  http_request_line_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Parser state as predicted from the bytes transferred so far
  logic [2:0]  p_phase;
  logic        p_cr;
  logic        p_line_end;
  logic [10:0] p_index;
  logic [15:0] p_body_len;

  hrlp_result_t awaited[$];
  dir_row_t     dir_rows[$];

  int n_sent;
  int n_checked;
  int n_bad;
  int n_cycles;
  int n_cfg;
  int n_body;
  int n_lines;
  bit calm;

  always #5 clk = ~clk;

  function automatic void enter_phase(input logic [2:0] p);
    p_phase    = p;
    p_cr       = 1'b0;
    p_line_end = 1'b0;
    p_index    = '0;
  endfunction

  function automatic logic [9:0] len_cap(input logic [10:0] n);
    return (n > 11'(LEN_TOP)) ? LEN_TOP : n[9:0];
  endfunction

  // Advance the predicted parser by one byte and return its result
  function automatic hrlp_result_t parse_byte(input logic [7:0] b);
    hrlp_result_t r;
    logic [10:0]  limit;
    logic [2:0]   cur;
    field_t       own_fld;
    bit           handled;
    r       = '0;
    cur     = p_phase;
    own_fld = (cur == PHC_METHOD) ? FLD_METHOD : FLD_PATH;
    handled = 1'b0;
    if (cur == PHC_BODY) begin
      limit = (p_body_len > 16'(BODY_MAX - 1)) ? 11'(BODY_MAX - 1) : p_body_len[10:0];
      r.store_target   = FLD_BODY;
      r.store_position = p_index[9:0];
      r.store_byte     = b;
      p_index = p_index + 11'd1;
      if (p_index >= limit) begin
        r.closed_field  = FLD_BODY;
        r.closed_length = len_cap(p_index);
        enter_phase(PHC_DONE);
      end
    end else if (cur <= PHC_HEADERS) begin
      // CR LF ends a line; a second one in a row ends the headers
      if (b == CH_LF && p_cr) begin
        if (cur <= PHC_VERSION) begin
          if (cur <= PHC_PATH) begin
            r.closed_field  = own_fld;
            r.closed_length = len_cap(p_index);
          end
          enter_phase(PHC_HEADERS);
          p_line_end = 1'b1;
          handled    = 1'b1;
        end else if (p_line_end) begin
          if (p_body_len == 16'd0) begin
            r.closed_field  = FLD_BODY;
            r.closed_length = '0;
            enter_phase(PHC_DONE);
          end else begin
            enter_phase(PHC_BODY);
          end
          handled = 1'b1;
        end else begin
          p_line_end = 1'b1;
        end
      end else if (b != CH_CR) begin
        p_line_end = 1'b0;
      end

      if (!handled) begin
        p_cr = (b == CH_CR);
        if (b == CH_SP && cur <= PHC_PATH) begin
          r.closed_field  = own_fld;
          r.closed_length = len_cap(p_index);
          enter_phase(cur + 3'd1);
        end else if (cur <= PHC_PATH) begin
          if (p_index < ((cur == PHC_METHOD) ? 11'(METHOD_MAX) : 11'(PATH_MAX))) begin
            r.store_target   = own_fld;
            r.store_position = p_index[9:0];
            r.store_byte     = b;
            p_index = p_index + 11'd1;
          end
        end else if (p_index < IDX_TOP) begin
          p_index = p_index + 11'd1;
        end
      end
    end
    r.request_done = (p_phase == PHC_DONE);
    r.phase        = p_phase;
    return r;
  endfunction

  function automatic hrlp_result_t mk_res(input field_t st, input int pos,
                                          input logic [7:0] sb, input field_t cf,
                                          input int cl, input logic [2:0] ph);
    hrlp_result_t r;
    r.store_target   = st;
    r.store_position = 10'(pos);
    r.store_byte     = sb;
    r.closed_field   = cf;
    r.closed_length  = 10'(cl);
    r.request_done   = (ph == PHC_DONE);
    r.phase          = ph;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed,
                                  input hrlp_result_t want);
    dir_row_t row;
    row.b     = b;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Mostly short pauses, a few long ones, none while calm
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Text byte for a field or line: never completes a CR LF pair
  function automatic logic [7:0] text_byte(input logic [7:0] prev, input bit allow_sp);
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 60)      b = 8'($urandom_range(8'h21, 8'h7E));
    else if (r < 72) b = 8'($urandom_range(0, 255));
    else if (r < 80) b = CH_CR;
    else if (r < 88) b = CH_LF;
    else             b = CH_SP;
    if (!allow_sp && b == CH_SP) b = "_";
    if (prev == CH_CR && b == CH_LF) b = "a";
    return b;
  endfunction

  // Transfer one byte and queue its predicted result
  task automatic send_byte(input logic [7:0] b);
    int pause;
    pause = pick_pause();
    @(negedge clk);
    if (pause > 0) begin
      in_bus.valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    awaited.push_back(parse_byte(b));
    n_sent++;
    if (n_sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // Hold the sender until every queued result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic set_body_length(input logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    p_body_len = v;
    n_cfg++;
  endtask

  // Result side: random stalls on ready
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_pause();
        out_bus.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    hrlp_result_t got;
    hrlp_result_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.store_target   = field_t'(out_bus.store_target);
      got.store_position = out_bus.store_position;
      got.store_byte     = out_bus.store_byte;
      got.closed_field   = field_t'(out_bus.closed_field);
      got.closed_length  = out_bus.closed_length;
      got.request_done   = out_bus.request_done;
      got.phase          = out_bus.phase;
      if (awaited.size() == 0) begin
        if (n_bad < 10) $display("unexpected result at cycle %0d", n_cycles);
        n_bad++;
      end else begin
        want = awaited.pop_front();
        if (got.store_target !== want.store_target ||
            got.store_position !== want.store_position ||
            got.store_byte !== want.store_byte ||
            got.closed_field !== want.closed_field ||
            got.closed_length !== want.closed_length ||
            got.request_done !== want.request_done ||
            got.phase !== want.phase) begin
          if (n_bad < 10) begin
            $display("result %0d: want tgt=%0d pos=%0d byte=%02h cls=%0d len=%0d done=%0b ph=%0d",
                     n_checked, want.store_target, want.store_position, want.store_byte,
                     want.closed_field, want.closed_length, want.request_done, want.phase);
            $display("result %0d: got  tgt=%0d pos=%0d byte=%02h cls=%0d len=%0d done=%0b ph=%0d",
                     n_checked, got.store_target, got.store_position, got.store_byte,
                     got.closed_field, got.closed_length, got.request_done, got.phase);
          end
          n_bad++;
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("[http_request_line_parser] ERROR");
      $finish;
    end
  end

  initial begin
    body_plan_t plan;
    logic [7:0] prev;
    logic [7:0] b;
    int         path_more;
    int         hdr_goal;
    int         line_len;
    int         cut_at;
    bit         crlf_path;
    bit         bare;

    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    enter_phase(PHC_METHOD);
    p_body_len = '0;
    calm       = 1'b0;

    // Method with extreme bytes, lone CR and LF, overflow past the limit
    add_row(8'h00, 1, mk_res(FLD_METHOD, 0, 8'h00, FLD_NONE, 0, PHC_METHOD));
    add_row(8'hFF, 1, mk_res(FLD_METHOD, 1, 8'hFF, FLD_NONE, 0, PHC_METHOD));
    add_row(CH_CR, 1, mk_res(FLD_METHOD, 2, CH_CR, FLD_NONE, 0, PHC_METHOD));
    add_row("G",   1, mk_res(FLD_METHOD, 3, "G", FLD_NONE, 0, PHC_METHOD));
    add_row(CH_LF, 1, mk_res(FLD_METHOD, 4, CH_LF, FLD_NONE, 0, PHC_METHOD));
    for (int i = 5; i < METHOD_MAX; i++) begin
      add_row(8'(8'h41 + i), 1, mk_res(FLD_METHOD, i, 8'(8'h41 + i), FLD_NONE, 0, PHC_METHOD));
    end
    add_row("X", 1, mk_res(FLD_NONE, 0, 8'h00, FLD_NONE, 0, PHC_METHOD));
    add_row("Y", 1, mk_res(FLD_NONE, 0, 8'h00, FLD_NONE, 0, PHC_METHOD));
    add_row(CH_SP, 1, mk_res(FLD_NONE, 0, 8'h00, FLD_METHOD, METHOD_MAX, PHC_PATH));
    add_row("/", 1, mk_res(FLD_PATH, 0, "/", FLD_NONE, 0, PHC_PATH));
    add_row(8'h7F, 0, '0);
    add_row(8'h80, 0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_body_length(16'hFFFF);

    foreach (dir_rows[k]) begin
      send_byte(dir_rows[k].b);
      if (dir_rows[k].typed) awaited[awaited.size() - 1] = dir_rows[k].want;
    end

    // Pause until everything is out, then change the register
    wait_drained();
    set_body_length(16'($urandom_range(0, 65535)));

    // Rest of the path: mostly short, sometimes past its limit
    path_more = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40) : $urandom_range(250, 275);
    prev = 8'h80;
    repeat (path_more) begin
      b = text_byte(prev, 1'b0);
      send_byte(b);
      prev = b;
    end

    // End the path with CR LF, or with a space and a version
    crlf_path = ($urandom_range(0, 3) == 0);
    if (!crlf_path) begin
      send_byte(CH_SP);
      prev = CH_SP;
      repeat ($urandom_range(0, 12)) begin
        b = text_byte(prev, 1'b1);
        send_byte(b);
        prev = b;
      end
    end
    send_byte(CH_CR);
    send_byte(CH_LF);

    // Pick how the body ends; a capped body leaves little room for headers
    case ($urandom_range(0, 9))
      0:       plan = BODY_EMPTY;
      1, 2, 3: plan = BODY_CAPPED;
      4, 5, 6: plan = BODY_SHORT;
      default: plan = BODY_CUT;
    endcase

    // Header lines with random content, or none at all
    bare     = ($urandom_range(0, 7) == 0);
    hdr_goal = (plan == BODY_CAPPED) ? $urandom_range(40, 80) : $urandom_range(380, 470);
    n_lines  = 0;
    if (!bare) begin
      do begin
        line_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 60);
        prev = CH_LF;
        for (int j = 0; j < line_len; j++) begin
          b = text_byte(prev, 1'b1);
          if (j == 0 && b == CH_CR) b = "h";
          send_byte(b);
          prev = b;
        end
        send_byte(CH_CR);
        send_byte(CH_LF);
        n_lines++;
        if (n_lines == 1) begin
          wait_drained();
          set_body_length(16'($urandom_range(0, 65535)));
        end
      end while (n_sent < hdr_goal);
    end

    // Set the body length before the blank line
    wait_drained();
    case (plan)
      BODY_EMPTY:  set_body_length(16'd0);
      BODY_CAPPED: set_body_length($urandom_range(0, 1) ? 16'hFFFF
                                                        : 16'($urandom_range(1023, 65535)));
      BODY_SHORT:  set_body_length(($urandom_range(0, 3) == 0) ? 16'd1
                                                               : 16'($urandom_range(2, 300)));
      default:     set_body_length(16'hFFFF);
    endcase
    send_byte(CH_CR);
    send_byte(CH_LF);

    // Body: raw bytes until the predicted parser reports done
    cut_at = (plan == BODY_CUT) ? $urandom_range(1, 200) : 500;
    n_body = 0;
    while (p_phase != PHC_DONE) begin
      if (n_body == cut_at && plan == BODY_CUT) begin
        wait_drained();
        set_body_length($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, cut_at)));
      end else if (n_body == cut_at && plan == BODY_CAPPED) begin
        wait_drained();
        set_body_length($urandom_range(0, 1) ? 16'd1023 : 16'hFFFF);
      end
      send_byte(8'($urandom_range(0, 255)));
      n_body++;
    end

    // Bytes after the request is done yield results with nothing stored or closed; fill up the run
    repeat (16) send_byte(8'($urandom_range(0, 255)));
    while (n_sent < ITEM_GOAL) send_byte(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (10) @(posedge clk);
    if (awaited.size() != 0) begin
      $display("%0d results never arrived", awaited.size());
      n_bad++;
    end

    $display("sent %0d bytes, checked %0d results, %0d mismatches, %0d body_length writes",
             n_sent, n_checked, n_bad, n_cfg);
    $display("path ended by %s, %0d header lines, body plan %s with %0d body bytes",
             crlf_path ? "CR LF" : "space", n_lines, plan.name(), n_body);
    if (n_bad == 0) begin
      $display("[http_request_line_parser] OK");
    end else begin
      $display("[http_request_line_parser] ERROR");
    end
    $finish;
  end

endmodule
